// ----- rtl/bmdp_pkg.sv -----
package bmdp_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_DUTY_STEP = 1'b0;
	localparam logic REG_HOLD_TICKS = 1'b1;

	localparam logic [5:0] DUTY_STEP_RST = 6'd5;
	localparam logic [7:0] HOLD_TICKS_RST = 8'd100;

	localparam logic [7:0] SW_MASK = 8'h33;
	localparam logic [7:0] SW_UP = 8'h32;
	localparam logic [7:0] SW_DOWN = 8'h31;
	localparam logic [7:0] SW_REVERSE = 8'h23;
	localparam logic [7:0] SW_STOP = 8'h13;

	localparam logic [7:0] SEG_BLANK = 8'hFF;
	localparam logic [7:0] SEG_MINUS = 8'hBF;

	localparam logic [6:0] DUTY_MAX = 7'd100;
	localparam logic [6:0] DUTY_RST = 7'd50;
	localparam logic [7:0] CMP_RST = 8'd128;

	localparam logic [1:0] DIGIT_UNITS = 2'd0;
	localparam logic [1:0] DIGIT_TENS = 2'd1;
	localparam logic [1:0] DIGIT_SIGN = 2'd2;
	localparam logic [1:0] DIGIT_UNUSED = 2'd3;

	localparam logic [1:0] SEL_UNITS = 2'd3;
	localparam logic [1:0] SEL_TENS = 2'd2;
	localparam logic [1:0] SEL_SIGN = 2'd1;

	localparam logic [1:0] DIR_FORWARD = 2'd2;
	localparam logic [1:0] DIR_REVERSE = 2'd1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] pin_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] pwm_compare;
		logic [1:0] dir_pins;
		logic [1:0] digit_select;
		logic [7:0] segments;
		logic [6:0] duty_percent;
		logic       stopped;
		logic       busy_res;
	} res_t;

	typedef struct packed {
		logic [5:0] duty_step;
		logic [7:0] reverse_hold_ticks;
	} cfg_t;

	function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/button_motor_duty_panel.sv -----
// Motor panel controller with push-button duty setting and a three-digit display.
// Command beats arrive on cmd_valid/cmd_stall/cmd: a beat is either a sample of the
// active-low switch port or a 5 ms display tick. Every command beat yields exactly
// one result beat on res_valid/res_stall/res carrying the PWM compare value,
// direction pins, the digit select and segment pattern, and status flags.
// A beat taken into the input register is processed as it moves on into the result
// register, which presents it; throughput is one beat per cycle while res_stall is low.
// The input register and the result register are separate, so a new command is
// taken while a finished result waits; cmd_stall rises only when both are full and
// res_stall is high. A stalled result holds its value until taken.
// The APB port holds duty_step at address 0 and reverse_hold_ticks at address 4;
// write them only while no beat is in flight. pready is always high.
// Reset gives duty 50 percent, compare 128, forward direction, blank display,
// duty_step 5 and reverse_hold_ticks 100, and empties both registers.
module button_motor_duty_panel
	import bmdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res
);

	cfg_t cfg;
	cmd_t cmd_s1;
	logic cmd_valid_s1;
	res_t res_next;
	res_t res_q;
	logic res_valid_q;
	logic advance;
	logic accept;

	assign pready = 1'b1;

	bmdp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign advance = cmd_valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = cmd_valid_s1 && !advance;
	assign accept = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (accept) begin
			cmd_valid_s1 <= 1'b1;
		end else if (advance) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	bmdp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (cmd_s1),
		.cfg     (cfg),
		.result  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (cmd_valid_s1 && res_valid_q && res_stall))
		else $error("command stalled with room downstream");

	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_s1 && !advance |=> cmd_valid_s1 && $stable(cmd_s1))
		else $error("pending command lost");

endmodule

// ----- rtl/bmdp_regs.sv -----
module bmdp_regs
	import bmdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	logic [5:0] duty_step_q;
	logic [7:0] hold_ticks_q;
	logic       wr_en;
	logic       idx;

	assign idx = paddr[2];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_step_q <= DUTY_STEP_RST;
			hold_ticks_q <= HOLD_TICKS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DUTY_STEP: duty_step_q <= pwdata[5:0];
				REG_HOLD_TICKS: hold_ticks_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DUTY_STEP: prdata = {{(APB_DATA_W-6){1'b0}}, duty_step_q};
			REG_HOLD_TICKS: prdata = {{(APB_DATA_W-8){1'b0}}, hold_ticks_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.duty_step = duty_step_q;
	assign cfg.reverse_hold_ticks = hold_ticks_q;

endmodule

// ----- rtl/bmdp_core.sv -----
module bmdp_core
	import bmdp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  cmd_t item,
	input  cfg_t cfg,
	output res_t result
);

	// Fixed-point reciprocal: d*255/100 equals (d*1336965) >> 19 for d up to 127.
	localparam logic [20:0] CMP_MULT = 21'd1336965;
	localparam logic [7:0] TENS_MULT = 8'd205;

	logic [6:0] duty_q, duty_n;
	logic [7:0] cmp_q, cmp_n;
	logic       stop_q, stop_n;
	logic       rev_q, rev_n;
	logic       latch_q, latch_n;
	logic [7:0] hold_q, hold_n;
	logic [1:0] digit_q, digit_n;
	logic [1:0] sel_q, sel_n;
	logic [7:0] seg_q, seg_n;

	logic [7:0]  sw;
	logic        is_updown;
	logic [7:0]  sum;
	logic [6:0]  duty_up;
	logic [6:0]  duty_down;
	logic [27:0] cmp_prod;
	logic [7:0]  cmp_calc;
	logic [14:0] tens_prod;
	logic [3:0]  tens_raw;
	logic [6:0]  units_raw;
	logic [3:0]  tens;
	logic [3:0]  units;

	assign sw = item.pin_value & SW_MASK;
	assign is_updown = (sw == SW_UP) || (sw == SW_DOWN);

	assign sum = {1'b0, duty_q} + {2'b00, cfg.duty_step};
	assign duty_up = (sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : sum[6:0];
	assign duty_down = (duty_q > {1'b0, cfg.duty_step}) ?
		(duty_q - {1'b0, cfg.duty_step}) : 7'd0;

	always_comb begin
		duty_n = duty_q;
		if (!item.req_type && hold_q == 8'd0 && is_updown && !latch_q && !stop_q) begin
			duty_n = (sw == SW_UP) ? duty_up : duty_down;
		end
	end

	assign cmp_prod = duty_n * CMP_MULT;
	assign cmp_calc = cmp_prod[26:19];

	assign tens_prod = duty_q * TENS_MULT;
	assign tens_raw = tens_prod[14:11];
	assign units_raw = duty_q - ({3'b000, tens_raw} * 7'd10);
	assign tens = (tens_raw >= 4'd10) ? 4'd9 : tens_raw;
	assign units = (tens_raw >= 4'd10) ? 4'd9 : units_raw[3:0];

	always_comb begin
		cmp_n = cmp_q;
		stop_n = stop_q;
		rev_n = rev_q;
		latch_n = latch_q;
		hold_n = hold_q;
		digit_n = digit_q;
		sel_n = sel_q;
		seg_n = seg_q;
		if (item.req_type) begin
			if (hold_q != 8'd0) begin
				hold_n = hold_q - 8'd1;
				seg_n = SEG_BLANK;
				if (hold_q == 8'd1) begin
					rev_n = !rev_q;
					cmp_n = cmp_calc;
				end
			end else begin
				unique case (digit_q)
					DIGIT_TENS: begin
						sel_n = SEL_TENS;
						seg_n = seg_of_digit(tens);
					end
					DIGIT_SIGN: begin
						sel_n = SEL_SIGN;
						seg_n = rev_q ? SEG_MINUS : SEG_BLANK;
					end
					DIGIT_UNITS, DIGIT_UNUSED: begin
						sel_n = SEL_UNITS;
						seg_n = seg_of_digit(units);
					end
					default: ;
				endcase
				digit_n = (digit_q >= DIGIT_SIGN) ? DIGIT_UNITS : digit_q + 2'd1;
			end
		end else if (hold_q == 8'd0) begin
			priority if (is_updown) begin
				if (!latch_q) begin
					latch_n = 1'b1;
					stop_n = 1'b0;
					cmp_n = cmp_calc;
				end
			end else if (sw == SW_REVERSE) begin
				if (!latch_q && !stop_q) begin
					latch_n = 1'b1;
					hold_n = cfg.reverse_hold_ticks;
					if (cfg.reverse_hold_ticks == 8'd0) begin
						rev_n = !rev_q;
						cmp_n = cmp_calc;
					end else begin
						cmp_n = 8'd0;
					end
				end
			end else if (sw == SW_STOP) begin
				if (!latch_q) begin
					latch_n = 1'b1;
					stop_n = 1'b1;
					cmp_n = 8'd0;
				end
			end else begin
				latch_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= DUTY_RST;
			cmp_q <= CMP_RST;
			stop_q <= 1'b0;
			rev_q <= 1'b0;
			latch_q <= 1'b0;
			hold_q <= 8'd0;
			digit_q <= DIGIT_TENS;
			sel_q <= SEL_UNITS;
			seg_q <= SEG_BLANK;
		end else if (advance) begin
			duty_q <= duty_n;
			cmp_q <= cmp_n;
			stop_q <= stop_n;
			rev_q <= rev_n;
			latch_q <= latch_n;
			hold_q <= hold_n;
			digit_q <= digit_n;
			sel_q <= sel_n;
			seg_q <= seg_n;
		end
	end

	assign result.pwm_compare = cmp_n;
	assign result.dir_pins = rev_n ? DIR_REVERSE : DIR_FORWARD;
	assign result.digit_select = sel_n;
	assign result.segments = seg_n;
	assign result.duty_percent = duty_n;
	assign result.stopped = stop_n;
	assign result.busy_res = (hold_n != 8'd0);

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= DUTY_MAX)
		else $error("duty above full scale");

	a_hold_motor_off: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q != 8'd0 |-> cmp_q == 8'd0)
		else $error("motor driven during reversal hold");

	a_digit_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q != DIGIT_UNUSED)
		else $error("digit index left its cycle");

endmodule
